@@ rtl/core/ipsp_pkg.sv @@
// ----------------------------------------------------------------------------
// IPS patch parser package
// Shared payload types, parse phases and constants of the IPS patch parser.
// ----------------------------------------------------------------------------
package ipsp_pkg;

   localparam int unsigned AddrWidth       = 25;
   localparam int unsigned LengthWidth     = 16;
   localparam int unsigned HeaderLeftWidth = 3;
   localparam logic [23:0] EofMarker       = 24'h454F46;

   typedef struct packed {
      logic [7:0] patch_byte;
      logic       new_patch;
   } req_payload_type;

   typedef struct packed {
      logic [AddrWidth-1:0]   write_address;
      logic [LengthWidth-1:0] run_length;
      logic [7:0]             fill_byte;
      logic                   patch_done;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_ADDR    = 3'd1,
      PH_SIZE    = 3'd2,
      PH_LITERAL = 3'd3,
      PH_RUNLEN  = 3'd4,
      PH_FILL    = 3'd5,
      PH_DONE    = 3'd6
   } phase_type;

   // Beat held in the input register.
   typedef struct packed {
      logic            valid;
      req_payload_type data;
   } item_type;

   // Result offered by the parser for the beat being consumed.
   typedef struct packed {
      logic            valid;
      rsp_payload_type data;
   } result_type;

endpackage

@@ rtl/core/ipsp_stream_if.sv @@
// ----------------------------------------------------------------------------
// IPS patch parser stream interface
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface ipsp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/ipsp_in_reg.sv @@
// ----------------------------------------------------------------------------
// IPS patch parser input register
// Registers each request beat; accepts a new beat when empty or whenever the held one leaves.
// ----------------------------------------------------------------------------
module ipsp_in_reg (
   input  logic              clock,
   input  logic              reset,
   ipsp_stream_if.sink       req_if,
   input  logic              take,
   output ipsp_pkg::item_type item
);

   logic                      valid_ff, valid_in;
   ipsp_pkg::req_payload_type data_ff;

   assign req_if.ready = !valid_ff || take;
   assign valid_in     = req_if.valid || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         data_ff <= req_if.data;
      end
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;

endmodule

@@ rtl/core/ipsp_parser.sv @@
// ----------------------------------------------------------------------------
// IPS patch parser core
// Parse state registers and the per-byte phase logic that forms each result.
// ----------------------------------------------------------------------------
module ipsp_parser #(
   parameter int unsigned HeaderBytes = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  ipsp_pkg::item_type   item,
   output ipsp_pkg::result_type result
);

   localparam logic [ipsp_pkg::HeaderLeftWidth-1:0] HeaderInit =
      ipsp_pkg::HeaderLeftWidth'(HeaderBytes);

   ipsp_pkg::phase_type                    phase_ff, phase_in;
   logic [ipsp_pkg::HeaderLeftWidth-1:0]   header_left_ff, header_left_in;
   logic [ipsp_pkg::AddrWidth-1:0]         record_address_ff, record_address_in;
   logic [ipsp_pkg::LengthWidth-1:0]       record_size_ff, record_size_in;
   logic [1:0]                             field_byte_index_ff, field_byte_index_in;

   logic [7:0] b;
   logic       skip;

   assign b = item.data.patch_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= ipsp_pkg::PH_HEADER;
         header_left_ff      <= HeaderInit;
         record_address_ff   <= '0;
         record_size_ff      <= '0;
         field_byte_index_ff <= '0;
      end else if (step) begin
         phase_ff            <= phase_in;
         header_left_ff      <= header_left_in;
         record_address_ff   <= record_address_in;
         record_size_ff      <= record_size_in;
         field_byte_index_ff <= field_byte_index_in;
      end
   end

   always_comb begin
      phase_in            = phase_ff;
      header_left_in      = header_left_ff;
      record_address_in   = record_address_ff;
      record_size_in      = record_size_ff;
      field_byte_index_in = field_byte_index_ff;
      skip                = 1'b0;
      result              = '0;

      if (item.data.new_patch) begin
         phase_in            = ipsp_pkg::PH_HEADER;
         header_left_in      = HeaderInit;
         record_address_in   = '0;
         record_size_in      = '0;
         field_byte_index_in = '0;
      end

      // Once the header count has run out, the same beat is the first address byte.
      if (phase_in == ipsp_pkg::PH_HEADER) begin
         if (header_left_in != '0) begin
            header_left_in = header_left_in - 1'b1;
            skip           = 1'b1;
         end else begin
            phase_in            = ipsp_pkg::PH_ADDR;
            field_byte_index_in = '0;
         end
      end

      if (!skip) begin
         unique case (phase_in)
            ipsp_pkg::PH_ADDR: begin
               record_address_in = {1'b0, record_address_in[15:0], b};
               if (field_byte_index_in < 2'd2) begin
                  field_byte_index_in = field_byte_index_in + 1'b1;
               end else begin
                  field_byte_index_in = '0;
                  if (record_address_in[23:0] == ipsp_pkg::EofMarker) begin
                     phase_in               = ipsp_pkg::PH_DONE;
                     result.valid           = 1'b1;
                     result.data.patch_done = 1'b1;
                  end else begin
                     record_size_in = '0;
                     phase_in       = ipsp_pkg::PH_SIZE;
                  end
               end
            end
            ipsp_pkg::PH_SIZE: begin
               record_size_in = {record_size_in[7:0], b};
               if (field_byte_index_in == '0) begin
                  field_byte_index_in = 2'd1;
               end else begin
                  field_byte_index_in = '0;
                  phase_in = (record_size_in == '0) ? ipsp_pkg::PH_RUNLEN
                                                    : ipsp_pkg::PH_LITERAL;
               end
            end
            ipsp_pkg::PH_LITERAL: begin
               result.valid              = 1'b1;
               result.data.write_address = record_address_in;
               result.data.run_length    = ipsp_pkg::LengthWidth'(1);
               result.data.fill_byte     = b;
               record_address_in         = record_address_in + 1'b1;
               record_size_in            = record_size_in - 1'b1;
               if (record_size_in == '0) begin
                  phase_in          = ipsp_pkg::PH_ADDR;
                  record_address_in = '0;
               end
            end
            ipsp_pkg::PH_RUNLEN: begin
               record_size_in = {record_size_in[7:0], b};
               if (field_byte_index_in == '0) begin
                  field_byte_index_in = 2'd1;
               end else begin
                  field_byte_index_in = '0;
                  phase_in            = ipsp_pkg::PH_FILL;
               end
            end
            ipsp_pkg::PH_FILL: begin
               // A run of length zero writes nothing.
               if (record_size_in != '0) begin
                  result.valid              = 1'b1;
                  result.data.write_address = record_address_in;
                  result.data.run_length    = record_size_in;
                  result.data.fill_byte     = b;
               end
               phase_in          = ipsp_pkg::PH_ADDR;
               record_address_in = '0;
               record_size_in    = '0;
            end
            default: begin
               // Done phase: bytes are ignored until the next patch starts.
            end
         endcase
      end
   end

   a_done_enters_done_phase: assert property (
      @(posedge clock) disable iff (reset)
      step && result.valid && result.data.patch_done |=> phase_ff == ipsp_pkg::PH_DONE
   ) else $error("done result did not leave the parser in the done phase");

   a_done_phase_silent: assert property (
      @(posedge clock) disable iff (reset)
      phase_ff == ipsp_pkg::PH_DONE && !item.data.new_patch |-> !result.valid
   ) else $error("result produced after the end-of-patch marker");

   a_write_has_length: assert property (
      @(posedge clock) disable iff (reset)
      result.valid && !result.data.patch_done |-> result.data.run_length != '0
   ) else $error("write result with zero length");

   a_done_fields_clear: assert property (
      @(posedge clock) disable iff (reset)
      result.valid && result.data.patch_done |->
         result.data.write_address == '0 && result.data.run_length == '0
   ) else $error("done result carries a nonzero address or length");

endmodule

@@ rtl/core/ipsp_out_reg.sv @@
// ----------------------------------------------------------------------------
// IPS patch parser output register
// Holds one result beat until the response side takes it.
// ----------------------------------------------------------------------------
module ipsp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  ipsp_pkg::result_type result,
   output logic                 space,
   ipsp_stream_if.source        rsp_if
);

   logic                      valid_ff, valid_in;
   ipsp_pkg::rsp_payload_type data_ff;

   assign space    = !valid_ff || rsp_if.ready;
   assign valid_in = load ? result.valid : (valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         data_ff <= result.data;
      end
   end

   assign rsp_if.valid = valid_ff;
   assign rsp_if.data  = data_ff;

endmodule

@@ rtl/core/ips_patch_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// IPS patch stream parser
// Parses an IPS patch byte stream into literal writes, run writes and done.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  req_if    in         patch_byte, new_patch
//  rsp_if    out        write_address, run_length, fill_byte, patch_done
//
//  One byte is taken every cycle while the output register has space; a
//  beat is held in the input register and its result, if any, is loaded
//  into the output register through the single phase update between them.
//  Reset is synchronous and returns the parser to the header phase.
//  A stall on rsp_if holds the output beat and backs up into req_if.ready.
// ----------------------------------------------------------------------------
module ips_patch_stream_parser_unit #(
   parameter int unsigned HeaderBytes = 5
) (
   input  logic          clock,
   input  logic          reset,
   ipsp_stream_if.sink   req_if,
   ipsp_stream_if.source rsp_if
);

   ipsp_pkg::item_type   item;
   ipsp_pkg::result_type result;
   logic                 space;
   logic                 take;

   assign take = item.valid && space;

   ipsp_in_reg u_in_reg (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .take   (take),
      .item   (item)
   );

   ipsp_parser #(
      .HeaderBytes (HeaderBytes)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (take),
      .item   (item),
      .result (result)
   );

   ipsp_out_reg u_out_reg (
      .clock  (clock),
      .reset  (reset),
      .load   (take),
      .result (result),
      .space  (space),
      .rsp_if (rsp_if)
   );

endmodule
